// File: rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// No dependencies; used by mi3_div_stage and matrix_inverse_3x3.
package mi3_pkg;

  localparam int NUM_ENTRIES = 9;
  localparam int Q_SHIFT     = 28;
  localparam int QUO_BITS    = 33;
  localparam int REM_W       = 60;
  localparam int DEN_W       = 48;

  // Cofactor k = a[COF_A[k]]*a[COF_B[k]] - a[COF_C[k]]*a[COF_D[k]]
  localparam logic [3:0] COF_A [NUM_ENTRIES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] COF_B [NUM_ENTRIES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] COF_C [NUM_ENTRIES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] COF_D [NUM_ENTRIES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [QUO_BITS-1:0] quo;
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_ENTRIES-1:0] lane;
    logic [DEN_W-1:0]        den;
    logic                    singular;
  } div_t;

endpackage

// File: rtl/mi3_div_stage.sv
// One registered restoring-division step for all nine lanes.
// Depends on mi3_pkg for the lane and stage types.
module mi3_div_stage #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mi3_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mi3_pkg::div_t out_data
);

  localparam int CMP_W = mi3_pkg::DEN_W + mi3_pkg::QUO_BITS;

  mi3_pkg::div_t data_next;
  logic [CMP_W-1:0] den_sh;

  assign in_ready = !out_valid || out_ready;
  assign den_sh   = CMP_W'(in_data.den) << BIT;

  always_comb begin
    data_next = in_data;
    for (int k = 0; k < mi3_pkg::NUM_ENTRIES; k++) begin
      if (CMP_W'(in_data.lane[k].rem) >= den_sh) begin
        data_next.lane[k].rem      = in_data.lane[k].rem - den_sh[mi3_pkg::REM_W-1:0];
        data_next.lane[k].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, Q4.12 in, Q16.16 out.
// Top level; depends on mi3_pkg and mi3_div_stage.
//
// Input channel: in_valid/in_ready with nine signed Q4.12 entries, row-major.
// Output channel: out_valid/out_ready with nine signed Q16.16 inverse entries,
// truncated toward zero, plus the singular and saturated flags.
// A zero determinant gives all-zero entries with singular set; quotients
// outside Q16.16 clip to the nearest limit and set saturated.
// Throughput: one item per cycle, sustained, whenever the receiver takes
// results. The pipeline is five stages of products, cofactors, determinant
// terms, sum and setup, then the restoring divider with one quotient bit per
// stage, 33 stages, and one output stage for sign and clipping.
// Each stage holds its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up while the receiver stalls and a
// stalled item is held, never lost or repeated. Reset clears the valid
// bits only; the pipeline is empty and in_ready is high right after reset.
module matrix_inverse_3x3 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] entry_0,
  input  logic signed [15:0] entry_1,
  input  logic signed [15:0] entry_2,
  input  logic signed [15:0] entry_3,
  input  logic signed [15:0] entry_4,
  input  logic signed [15:0] entry_5,
  input  logic signed [15:0] entry_6,
  input  logic signed [15:0] entry_7,
  input  logic signed [15:0] entry_8,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] inv_0,
  output logic signed [31:0] inv_1,
  output logic signed [31:0] inv_2,
  output logic signed [31:0] inv_3,
  output logic signed [31:0] inv_4,
  output logic signed [31:0] inv_5,
  output logic signed [31:0] inv_6,
  output logic signed [31:0] inv_7,
  output logic signed [31:0] inv_8,
  output logic               singular,
  output logic               saturated
);

  localparam int N  = mi3_pkg::NUM_ENTRIES;
  localparam int QB = mi3_pkg::QUO_BITS;

  logic signed [15:0] a [N];

  assign a[0] = entry_0;
  assign a[1] = entry_1;
  assign a[2] = entry_2;
  assign a[3] = entry_3;
  assign a[4] = entry_4;
  assign a[5] = entry_5;
  assign a[6] = entry_6;
  assign a[7] = entry_7;
  assign a[8] = entry_8;

  // Stage 1: the eighteen 16x16 products of the cofactors.
  logic               v1, r1;
  logic signed [31:0] prod_p [N];
  logic signed [31:0] prod_n [N];
  logic signed [15:0] row1 [3];

  // Stage 2: cofactors.
  logic               v2, r2;
  logic signed [32:0] cof2 [N];
  logic signed [15:0] row2 [3];

  // Stage 3: first-row expansion terms.
  logic               v3, r3;
  logic signed [32:0] cof3 [N];
  logic signed [48:0] term [3];

  // Stage 4: determinant.
  logic               v4, r4;
  logic signed [32:0] cof4 [N];
  logic signed [49:0] det;

  // Stage 5: divider setup, then the division chain.
  logic                 v5, r5;
  mi3_pkg::div_t        setup_next;
  mi3_pkg::div_t        div_data  [QB+1];
  logic                 div_valid [QB+1];
  logic                 div_ready [QB+1];

  // Output stage.
  logic               r6;
  logic signed [31:0] inv_next [N];
  logic signed [31:0] inv_q    [N];
  logic               sat_next;

  assign r6 = !out_valid || out_ready;
  assign r5 = !v5 || div_ready[0];
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) out_valid <= div_valid[QB];
    end
  end

  // Products.
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      for (int k = 0; k < N; k++) begin
        prod_p[k] <= a[mi3_pkg::COF_A[k]] * a[mi3_pkg::COF_B[k]];
        prod_n[k] <= a[mi3_pkg::COF_C[k]] * a[mi3_pkg::COF_D[k]];
      end
      for (int j = 0; j < 3; j++) row1[j] <= a[j];
    end
  end

  // Cofactors.
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      for (int k = 0; k < N; k++) begin
        cof2[k] <= 33'(prod_p[k]) - 33'(prod_n[k]);
      end
      row2 <= row1;
    end
  end

  // Expansion terms a0j * C(j,0) live in cofactors 0, 3 and 6.
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= 49'(row2[j]) * 49'(cof2[3*j]);
      end
      cof3 <= cof2;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      det  <= 50'(term[0]) + 50'(term[1]) + 50'(term[2]);
      cof4 <= cof3;
    end
  end

  // Setup: magnitudes, sign and the early overflow test q >= 2^33.
  always_comb begin
    logic [32:0]              neg_cof;
    logic [49:0]              neg_det;
    logic [31:0]              mag;
    logic [mi3_pkg::REM_W-1:0] num;
    setup_next = '0;
    neg_det = -det;
    setup_next.den = det[49] ? neg_det[mi3_pkg::DEN_W-1:0] : det[mi3_pkg::DEN_W-1:0];
    setup_next.singular = (det == '0);
    for (int k = 0; k < N; k++) begin
      neg_cof = -cof4[k];
      mag = cof4[k][32] ? neg_cof[31:0] : cof4[k][31:0];
      num = {mag, {mi3_pkg::Q_SHIFT{1'b0}}};
      setup_next.lane[k].rem = num;
      setup_next.lane[k].neg = cof4[k][32] ^ det[49];
      setup_next.lane[k].ovf =
        mi3_pkg::DEN_W'(num[mi3_pkg::REM_W-1:QB]) >= setup_next.den;
    end
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      div_data[0] <= setup_next;
    end
  end

  assign div_valid[0] = v5;
  assign div_ready[QB] = r6;

  // Division chain: one quotient bit per stage, most significant first.
  for (genvar s = 0; s < QB; s++) begin : g_div
    mi3_div_stage #(
      .BIT (QB - 1 - s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_data   (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  // Apply sign, clip to Q16.16, and drop everything for a singular matrix.
  always_comb begin
    mi3_pkg::lane_t ln;
    logic           clip;
    logic [QB-1:0]  negq;
    sat_next = 1'b0;
    for (int k = 0; k < N; k++) begin
      ln   = div_data[QB].lane[k];
      negq = -ln.quo;
      if (ln.neg) begin
        clip = ln.ovf || ln.quo[32] || (ln.quo[31] && (ln.quo[30:0] != '0));
      end else begin
        clip = ln.ovf || ln.quo[32] || ln.quo[31];
      end
      if (div_data[QB].singular) begin
        inv_next[k] = '0;
      end else if (clip) begin
        inv_next[k] = ln.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        sat_next = 1'b1;
      end else begin
        inv_next[k] = ln.neg ? negq[31:0] : ln.quo[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r6 && div_valid[QB]) begin
      inv_q     <= inv_next;
      singular  <= div_data[QB].singular;
      saturated <= sat_next;
    end
  end

  assign inv_0 = inv_q[0];
  assign inv_1 = inv_q[1];
  assign inv_2 = inv_q[2];
  assign inv_3 = inv_q[3];
  assign inv_4 = inv_q[4];
  assign inv_5 = inv_q[5];
  assign inv_6 = inv_q[6];
  assign inv_7 = inv_q[7];
  assign inv_8 = inv_q[8];

endmodule

// File: tb/tb.sv
// Self-checking bench for matrix_inverse_3x3: matrices in, checked inverses out.
// Depends on the RTL top level and mi3_pkg; needs no files or arguments.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS   = 2000;
  localparam int WD_LIMIT  = 5000;  // idle cycles allowed before giving up
  localparam int HOLD_LEN  = 300;   // long receiver hold-off, in cycles
  localparam int DRAIN_CYC = 60;    // drain margin, longer than the pipeline latency

  typedef struct {
    logic [31:0] inv [9];
    logic        sing;
    logic        sat;
  } inverse_t;

  // Holds the inverses expected for matrices taken by the block, oldest first.
  class inverse_scoreboard;
    inverse_t pending [$];
    int       errors;
    int       n_checked;
    int       n_singular;
    int       n_saturated;

    // Divide one cofactor by the determinant into Q16.16, truncating toward zero.
    function automatic logic [31:0] q16_quotient(longint cof, longint det, ref logic sat);
      longint unsigned num, den, q;
      bit neg;
      num = longint'(cof < 0 ? -cof : cof);
      num = num << mi3_pkg::Q_SHIFT;
      den = longint'(det < 0 ? -det : det);
      q   = num / den;
      neg = (cof < 0) != (det < 0);
      if (!neg) begin
        if (q > 64'h7FFF_FFFF) begin
          sat = 1'b1;
          return 32'h7FFF_FFFF;
        end
        return q[31:0];
      end
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      q = -q;
      return q[31:0];
    endfunction

    // Predict the inverse of one accepted matrix and queue it.
    function void note_matrix(logic signed [15:0] e [9]);
      longint   a [9];
      longint   adj [9];
      longint   det;
      inverse_t x;
      for (int i = 0; i < 9; i++) a[i] = longint'(e[i]);
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      x.sat  = 1'b0;
      x.sing = (det == 0);
      for (int k = 0; k < 9; k++)
        x.inv[k] = x.sing ? 32'h0 : q16_quotient(adj[k], det, x.sat);
      pending.push_back(x);
    endfunction

    // Compare one result with the oldest expected inverse.
    function void check_result(inverse_t got);
      inverse_t x;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, inv_0 %h", $time, got.inv[0]);
        return;
      end
      x = pending.pop_front();
      n_checked++;
      if (x.sing) n_singular++;
      if (x.sat)  n_saturated++;
      for (int k = 0; k < 9; k++)
        if (got.inv[k] !== x.inv[k]) begin
          errors++;
          $display("%0t: inv_%0d expected %h actual %h", $time, k, x.inv[k], got.inv[k]);
        end
      if (got.sing !== x.sing) begin
        errors++;
        $display("%0t: singular expected %b actual %b", $time, x.sing, got.sing);
      end
      if (got.sat !== x.sat) begin
        errors++;
        $display("%0t: saturated expected %b actual %b", $time, x.sat, got.sat);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] ent [9] = '{default: 16'sd0};
  logic signed [31:0] inv [9];
  logic               singular;
  logic               saturated;

  inverse_scoreboard sb = new();
  int  n_sent = 0;
  bit  quiet = 1'b0;     // no idling on either side while set
  bit  hold_done = 1'b0;
  int  idle_cycles = 0;

  always #10 clk = ~clk;

  matrix_inverse_3x3 u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .entry_0(ent[0]), .entry_1(ent[1]), .entry_2(ent[2]),
    .entry_3(ent[3]), .entry_4(ent[4]), .entry_5(ent[5]),
    .entry_6(ent[6]), .entry_7(ent[7]), .entry_8(ent[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .inv_0(inv[0]), .inv_1(inv[1]), .inv_2(inv[2]),
    .inv_3(inv[3]), .inv_4(inv[4]), .inv_5(inv[5]),
    .inv_6(inv[6]), .inv_7(inv[7]), .inv_8(inv[8]),
    .singular(singular), .saturated(saturated)
  );

  // Monitor: sample both handshakes at the rising edge, run the watchdog.
  always @(posedge clk) begin
    inverse_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_matrix(ent);
      if (out_valid && out_ready) begin
        for (int k = 0; k < 9; k++) got.inv[k] = inv[k];
        got.sing = singular;
        got.sat  = saturated;
        sb.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (sb.pending.size() == 0 && !in_valid))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the pipeline up.
  always @(negedge clk) begin
    int hold_left;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_sent >= 1500) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  // Offer the matrix in ent; idle now and then first, hold until taken.
  task automatic send_matrix();
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic set_matrix(input logic signed [15:0] m [9]);
    for (int i = 0; i < 9; i++) ent[i] = m[i];
  endtask

  // Build a random matrix of one of several shapes, weighted toward the
  // near-singular and dependent ones where singular and saturated live.
  task automatic random_matrix();
    int kind, r, s, d;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) ent[i] = 16'($urandom);
    if (kind < 35) begin
      // keep full random
    end else if (kind < 55) begin
      for (int i = 0; i < 9; i++) ent[i] = 16'($urandom_range(8)) - 16'sd4;
    end else if (kind < 70) begin
      // copy or negate one row into another
      r = $urandom_range(2);
      s = (r + $urandom_range(2, 1)) % 3;
      for (int c = 0; c < 3; c++)
        ent[3*s+c] = ($urandom_range(1) && ent[3*r+c] != -16'sd32768) ?
                     -ent[3*r+c] : ent[3*r+c];
    end else if (kind < 90) begin
      // one row nearly equal to another
      r = $urandom_range(2);
      s = (r + $urandom_range(2, 1)) % 3;
      for (int c = 0; c < 3; c++) begin
        ent[3*r+c] = 16'($urandom_range(60000)) - 16'sd30000;
        d = $urandom_range(6) - 3;
        ent[3*s+c] = ent[3*r+c] + 16'(d);
      end
    end else begin
      for (int i = 0; i < 9; i++)
        if (i % 4 != 0) ent[i] = 16'($urandom_range(64)) - 16'sd32;
    end
  endtask

  initial begin
    logic signed [15:0] m [9];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: all zero, identity, extremes, a clipping pair each way.
    m = '{default: 16'sd0};                       set_matrix(m); send_matrix();
    m = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
    set_matrix(m); send_matrix();
    m = '{default: -16'sd32768};                  set_matrix(m); send_matrix();
    m = '{default: 16'sd32767};                   set_matrix(m); send_matrix();
    m = '{16'sd32767, 0, 0, 0, 16'sd32767, 0, 0, 0, 16'sd32767};
    set_matrix(m); send_matrix();
    m = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768};
    set_matrix(m); send_matrix();
    m = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
    set_matrix(m); send_matrix();
    m = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, -16'sd1};
    set_matrix(m); send_matrix();
    m = '{16'sd32767, 16'sd32766, 0, 16'sd32766, 16'sd32765, 0, 0, 0, 16'sd32767};
    set_matrix(m); send_matrix();
    m = '{16'sd32767, 16'sd32766, 0, 16'sd32766, 16'sd32765, 0, 0, 0, -16'sd32767};
    set_matrix(m); send_matrix();
    m = '{16'sd3, 16'sd5, 16'sd7, 16'sd6, 16'sd10, 16'sd14, 16'sd1, 16'sd2, 16'sd9};
    set_matrix(m); send_matrix();
    m = '{0, 16'sh1000, 0, 0, 0, 16'sh1000, 16'sh1000, 0, 0};
    set_matrix(m); send_matrix();
    m = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
          16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767};
    set_matrix(m); send_matrix();

    // Random part, with a stretch of back-to-back traffic in the middle.
    for (int n = 0; n < N_ITEMS; n++) begin
      quiet = (n >= 600 && n < 1000);
      random_matrix();
      send_matrix();
    end
    in_valid <= 1'b0;
    quiet = 1'b1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
             n_sent, sb.n_checked, sb.n_singular, sb.n_saturated);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: matrix_inverse_3x3.f
rtl/mi3_pkg.sv
rtl/mi3_div_stage.sv
rtl/matrix_inverse_3x3.sv
tb/tb.sv
